FILE: hw/rtl/redundant_frame_inserter_defines.svh
// Assertion macros shared by the redundant frame inserter checkers.
`ifndef REDUNDANT_FRAME_INSERTER_DEFINES_SVH
`define REDUNDANT_FRAME_INSERTER_DEFINES_SVH

// Same-cycle implication on the block clock, idle during reset.
`define RFI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on the block clock, idle during reset.
`define RFI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/rfi_pkg.sv
// Types, constants and helpers for the redundant frame inserter.
`timescale 1ns / 1ps

package rfi_pkg;

   // ring geometry; RING_SLOTS must be a power of two (slot = sequence low bits)
   localparam int RING_SLOTS    = 256;
   localparam int PAYLOAD_WORDS = 40;
   localparam int SLOT_W        = $clog2(RING_SLOTS);
   localparam int POS_W         = $clog2(PAYLOAD_WORDS + 1);
   localparam int CNT_W         = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
   localparam int MEM_DEPTH     = RING_SLOTS * PAYLOAD_WORDS;
   localparam int ADDR_W        = $clog2(MEM_DEPTH);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // budget credit, tenths of a byte
   localparam int CREDIT_W    = 48;
   localparam int DELTA_W     = 18;
   localparam int COST_PLAIN  = 40 * (1 + PAYLOAD_WORDS);
   localparam int COST_DOUBLE = 40 * (1 + 2 * PAYLOAD_WORDS);
   localparam logic signed [CREDIT_W-1:0] COST_DOUBLE_C   = CREDIT_W'(COST_DOUBLE);
   localparam logic signed [DELTA_W-1:0]  NEG_COST_PLAIN  = DELTA_W'(-COST_PLAIN);
   localparam logic signed [DELTA_W-1:0]  NEG_COST_DOUBLE = DELTA_W'(-COST_DOUBLE);
   localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = {1'b0, {(CREDIT_W-1){1'b1}}};
   localparam logic signed [CREDIT_W-1:0] CREDIT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

   // register file
   localparam int          CSR_ADDR_W     = 3;
   localparam logic [7:0]  RESET_DISTANCE = 8'd2;
   localparam logic [15:0] RESET_BUDGET   = 16'd3168;

   typedef enum logic [0:0] {
      REG_DISTANCE = 1'b0,
      REG_BUDGET   = 1'b1
   } csr_index_type;

   typedef enum logic {
      FRONT_TAKE,
      FRONT_DECIDE
   } front_state_type;

   typedef enum logic {
      BACK_PASS,
      BACK_COPY
   } back_state_type;

   // one queued command: a pass-through word, optionally followed by an append
   typedef struct packed {
      logic [31:0]       word;
      logic              last;
      logic              append;
      logic [SLOT_W-1:0] src_slot;
      logic [ADDR_W-1:0] src_base;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       data;
   } ring_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] addr;
   } ring_rd_type;

   // saturating add of a small signed delta to the credit
   function automatic logic signed [CREDIT_W-1:0] credit_sat_add(
      input logic signed [CREDIT_W-1:0] a,
      input logic signed [DELTA_W-1:0]  b
   );
      logic [CREDIT_W:0] s;
      s = {a[CREDIT_W-1], a} + {{(CREDIT_W + 1 - DELTA_W){b[DELTA_W-1]}}, b};
      if (s[CREDIT_W] != s[CREDIT_W-1]) begin
         return s[CREDIT_W] ? CREDIT_MIN : CREDIT_MAX;
      end
      return s[CREDIT_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/rfi_if.sv
// Item channel interfaces: input words and outgoing datagram words.
`timescale 1ns / 1ps

interface rfi_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] in_word;

   modport source (output valid, output in_word, input ready);
   modport sink   (input valid, input in_word, output ready);
endinterface

interface rfi_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word;
   logic        out_last;
   logic        out_copy;

   modport source (output valid, output out_word, output out_last, output out_copy,
                   input ready);
   modport sink   (input valid, input out_word, input out_last, input out_copy,
                   output ready);
endinterface

FILE: hw/rtl/rfi_ring.sv
// Payload ring memory with per-slot valid bits; unwritten slots read as zero.
`timescale 1ns / 1ps

module rfi_ring
   import rfi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ring_wr_type ring_wr,
   input  ring_rd_type ring_rd,
   output logic [31:0] rd_data
);

   logic [31:0]           mem_ff [MEM_DEPTH];
   logic [RING_SLOTS-1:0] slot_valid_ff;
   logic [31:0]           rd_word_ff;
   logic                  rd_hit_ff;

   always_ff @(posedge clock) begin
      if (ring_wr.en) begin
         mem_ff[ring_wr.addr] <= ring_wr.data;
      end
      if (ring_rd.en) begin
         rd_word_ff <= mem_ff[ring_rd.addr];
         rd_hit_ff  <= slot_valid_ff[ring_rd.slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (ring_wr.en) begin
         slot_valid_ff[ring_wr.slot] <= 1'b1;
      end
   end

   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule

FILE: hw/rtl/rfi_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module rfi_queue
   import rfi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

endmodule

FILE: hw/rtl/rfi_front.sv
// Front part: takes input words, fills the ring, keeps the budget, queues commands.
`timescale 1ns / 1ps

module rfi_front
   import rfi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rfi_req_if.sink     req_chan,
   input  logic [7:0]  distance,
   input  logic [15:0] budget,
   input  logic        q_full,
   input  logic        append_done,
   output logic        q_push,
   output cmd_type     q_cmd,
   output ring_wr_type ring_wr
);

   front_state_type              state_ff, state_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [31:0]                  seq_ff, seq_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [ADDR_W-1:0]            wr_addr_ff, wr_addr_in;
   logic [31:0]                  last_word_ff, last_word_in;
   logic signed [CREDIT_W-1:0]   credit_ff, credit_in;
   logic                         busy_ff, busy_in;
   logic                         take_ready;
   logic                         accept;
   logic                         at_seq;
   logic                         at_last;
   logic                         append_ok;
   logic [SLOT_W-1:0]            src_slot;

   assign at_seq    = (pos_ff == '0);
   assign at_last   = (pos_ff == POS_W'(PAYLOAD_WORDS));
   assign accept    = req_chan.valid && take_ready;
   assign append_ok = (seq_ff >= 32'(distance)) && (credit_ff >= COST_DOUBLE_C);
   assign src_slot  = seq_ff[SLOT_W-1:0] - SLOT_W'(distance);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_TAKE: begin
            if (accept && at_last) begin
               state_in = FRONT_DECIDE;
            end
         end
         FRONT_DECIDE: begin
            if (!q_full) begin
               state_in = FRONT_TAKE;
            end
         end
         default: state_in = FRONT_TAKE;
      endcase
   end

   // outputs: payload words wait while an append is still reading the ring
   always_comb begin
      take_ready = 1'b0;
      q_push     = 1'b0;
      q_cmd      = '0;
      unique case (state_ff)
         FRONT_TAKE: begin
            take_ready = !q_full && !(busy_ff && !at_seq);
            q_push     = req_chan.valid && take_ready && !at_last;
            q_cmd.word = req_chan.in_word;
         end
         FRONT_DECIDE: begin
            q_push         = !q_full;
            q_cmd.word     = last_word_ff;
            q_cmd.last     = !append_ok;
            q_cmd.append   = append_ok;
            q_cmd.src_slot = src_slot;
            q_cmd.src_base = ADDR_W'(src_slot) * ADDR_W'(PAYLOAD_WORDS);
         end
         default: begin
            take_ready = 1'b0;
         end
      endcase
      req_chan.ready = take_ready;
   end

   // datapath next values
   always_comb begin
      pos_in       = pos_ff;
      seq_in       = seq_ff;
      slot_in      = slot_ff;
      wr_addr_in   = wr_addr_ff;
      last_word_in = last_word_ff;
      credit_in    = credit_ff;
      busy_in      = busy_ff;
      if (accept) begin
         if (at_seq) begin
            pos_in     = POS_W'(1);
            seq_in     = req_chan.in_word;
            slot_in    = req_chan.in_word[SLOT_W-1:0];
            wr_addr_in = ADDR_W'(req_chan.in_word[SLOT_W-1:0]) * ADDR_W'(PAYLOAD_WORDS);
         end else begin
            wr_addr_in = wr_addr_ff + 1'b1;
            if (at_last) begin
               pos_in       = '0;
               last_word_in = req_chan.in_word;
               credit_in    = credit_sat_add(credit_ff, DELTA_W'(budget));
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
      // second budget step: charge the datagram actually sent
      if (state_ff == FRONT_DECIDE && !q_full) begin
         credit_in = credit_sat_add(credit_ff, append_ok ? NEG_COST_DOUBLE : NEG_COST_PLAIN);
         busy_in   = append_ok;
      end else if (append_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FRONT_TAKE;
         pos_ff    <= '0;
         credit_ff <= '0;
         busy_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         credit_ff <= credit_in;
         busy_ff   <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff       <= seq_in;
      slot_ff      <= slot_in;
      wr_addr_ff   <= wr_addr_in;
      last_word_ff <= last_word_in;
   end

   assign ring_wr.en   = accept && !at_seq;
   assign ring_wr.slot = slot_ff;
   assign ring_wr.addr = wr_addr_ff;
   assign ring_wr.data = req_chan.in_word;

endmodule

FILE: hw/rtl/rfi_back.sv
// Back part: drains the command queue, streams ring copies, holds the output register.
`timescale 1ns / 1ps

module rfi_back
   import rfi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     q_head,
   input  logic        q_empty,
   output logic        q_pop,
   output ring_rd_type ring_rd,
   input  logic [31:0] ring_data,
   output logic        append_done,
   rfi_rsp_if.source   rsp_chan
);

   back_state_type    state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_copy_ff, rsp_copy_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_last_ff, rd_last_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              out_free;
   logic              move;
   logic              issue;
   logic              cnt_end;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign move     = rd_valid_ff && out_free;
   assign cnt_end  = (rd_cnt_ff == CNT_W'(PAYLOAD_WORDS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_PASS: begin
            if (q_pop && q_head.append) begin
               state_in = BACK_COPY;
            end
         end
         BACK_COPY: begin
            if (issue && cnt_end) begin
               state_in = BACK_PASS;
            end
         end
         default: state_in = BACK_PASS;
      endcase
   end

   // outputs: a new command only once the read stage has drained
   always_comb begin
      q_pop       = 1'b0;
      issue       = 1'b0;
      append_done = 1'b0;
      unique case (state_ff)
         BACK_PASS: begin
            q_pop = !q_empty && out_free && !rd_valid_ff;
         end
         BACK_COPY: begin
            issue       = !rd_valid_ff || out_free;
            append_done = issue && cnt_end;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_copy_in  = rsp_copy_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = q_head.word;
         rsp_last_in  = q_head.last;
         rsp_copy_in  = 1'b0;
      end else if (move) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = ring_data;
         rsp_last_in  = rd_last_ff;
         rsp_copy_in  = 1'b1;
      end

      rd_valid_in = issue ? 1'b1 : (move ? 1'b0 : rd_valid_ff);
      rd_last_in  = issue ? cnt_end : rd_last_ff;
      rd_addr_in  = rd_addr_ff;
      rd_slot_in  = rd_slot_ff;
      rd_cnt_in   = rd_cnt_ff;
      if (q_pop) begin
         rd_addr_in = q_head.src_base;
         rd_slot_in = q_head.src_slot;
         rd_cnt_in  = '0;
      end else if (issue) begin
         rd_addr_in = rd_addr_ff + 1'b1;
         rd_cnt_in  = rd_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_PASS;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_copy_ff <= rsp_copy_in;
      rd_last_ff  <= rd_last_in;
      rd_addr_ff  <= rd_addr_in;
      rd_slot_ff  <= rd_slot_in;
      rd_cnt_ff   <= rd_cnt_in;
   end

   assign ring_rd.en        = issue;
   assign ring_rd.slot      = rd_slot_ff;
   assign ring_rd.addr      = rd_addr_ff;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_word = rsp_word_ff;
   assign rsp_chan.out_last = rsp_last_ff;
   assign rsp_chan.out_copy = rsp_copy_ff;

endmodule

FILE: hw/rtl/redundant_frame_inserter.sv
// Top level of the redundant frame inserter: register port and part wiring.
`timescale 1ns / 1ps

// Frames come in as 41 words (sequence number, then 40 payload words); every
// word is passed straight out, and each payload word is also kept in a ring of
// 256 frame slots picked by the low bits of the sequence. At the end of a frame
// the budget credit (saturating, signed, tenths of a byte) decides whether the
// payload of the frame redundancy_distance back is appended as 40 more words
// flagged out_copy, the last of them carrying out_last. Timing: the front takes
// one input item per cycle while the command queue has room, and adds a decide
// state at the last word of each frame for the budget decision. The back
// delivers one result item per cycle from its output register while the
// receiver keeps ready high. While an append is still reading the ring, the
// next frame's sequence word is taken but its payload waits. Ring slots carry
// a valid bit each, cleared by reset, so there is no clearing pass: the block
// takes items right after reset. Registers: 0x0 redundancy_distance (8 bit,
// reset 2), 0x4 budget_per_frame_tenths (16 bit, reset 3168); writes land on
// the APB access cycle, pready is tied high.

module redundant_frame_inserter
   import rfi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rfi_req_if.sink               req_chan,
   rfi_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [7:0]    distance_ff, distance_in;
   logic [15:0]   budget_ff, budget_in;
   logic          csr_write;
   csr_index_type csr_index;

   cmd_type       q_cmd;
   cmd_type       q_head;
   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   logic          append_done;
   ring_wr_type   ring_wr;
   ring_rd_type   ring_rd;
   logic [31:0]   ring_data;

   // register port: byte offset bits are ignored, word index picks the register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[2]);

   always_comb begin
      distance_in = distance_ff;
      budget_in   = budget_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DISTANCE: distance_in = pwdata[7:0];
            REG_BUDGET:   budget_in   = pwdata[15:0];
            default:      distance_in = distance_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DISTANCE: prdata = {24'd0, distance_ff};
         REG_BUDGET:   prdata = {16'd0, budget_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_ff <= RESET_DISTANCE;
         budget_ff   <= RESET_BUDGET;
      end else begin
         distance_ff <= distance_in;
         budget_ff   <= budget_in;
      end
   end

   // front: classify words, fill the ring, run the budget
   rfi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .distance    (distance_ff),
      .budget      (budget_ff),
      .q_full      (q_full),
      .append_done (append_done),
      .q_push      (q_push),
      .q_cmd       (q_cmd),
      .ring_wr     (ring_wr)
   );

   // decouples input side stalls from output side stalls
   rfi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   rfi_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .ring_wr (ring_wr),
      .ring_rd (ring_rd),
      .rd_data (ring_data)
   );

   // back: pass words out, stream the redundant copy
   rfi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .ring_rd     (ring_rd),
      .ring_data   (ring_data),
      .append_done (append_done),
      .rsp_chan    (rsp_chan)
   );

endmodule

FILE: hw/rtl/rfi_checker.sv
// Port-level checks on the redundant frame inserter, bound to the top level.
`timescale 1ns / 1ps
`include "redundant_frame_inserter_defines.svh"

module rfi_checker
   import rfi_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word,
   input logic        rsp_last,
   input logic        rsp_copy
);

   logic             req_acc;
   logic             rsp_acc;
   logic [7:0]       pend_ff, pend_in;
   logic [CNT_W-1:0] copy_cnt_ff, copy_cnt_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // input items not yet matched by a pass-through result
   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !(rsp_acc && !rsp_copy)) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_acc && rsp_acc && !rsp_copy) begin
         pend_in = pend_ff - 1'b1;
      end
      copy_cnt_in = copy_cnt_ff;
      if (rsp_acc) begin
         copy_cnt_in = (rsp_copy && !rsp_last) ? copy_cnt_ff + 1'b1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         copy_cnt_ff <= '0;
      end else begin
         pend_ff     <= pend_in;
         copy_cnt_ff <= copy_cnt_in;
      end
   end

   `RFI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word) && $stable(rsp_last) && $stable(rsp_copy), "stalled result item changed")
   `RFI_ASSERT_IMP(a_no_invented, rsp_acc && !rsp_copy, pend_ff != '0, "pass-through item without input")
   `RFI_ASSERT_IMP(a_copy_len, rsp_acc && rsp_copy && rsp_last, copy_cnt_ff == CNT_W'(PAYLOAD_WORDS - 1), "redundant copy of wrong length")
   `RFI_ASSERT_IMP(a_copy_open, rsp_acc && rsp_copy && !rsp_last, copy_cnt_ff != CNT_W'(PAYLOAD_WORDS - 1), "redundant copy overruns payload")
   `RFI_ASSERT_IMP(a_reset_quiet, $past(reset), !rsp_valid, "result valid straight after reset")

endmodule

bind redundant_frame_inserter rfi_checker u_rfi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.out_word),
   .rsp_last  (rsp_chan.out_last),
   .rsp_copy  (rsp_chan.out_copy)
);

FILE: dv/rfi_checker.sv
// Checker for the redundant frame inserter: predicts outgoing words and compares them.
`timescale 1ns / 1ps

module rfi_scoreboard
   import rfi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [31:0]           req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [31:0]           rsp_word,
   input  logic                  rsp_last,
   input  logic                  rsp_copy,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic [31:0] word;
      logic        last;
      logic        copy;
   } dgram_word_type;

   localparam longint CREDIT_CEIL  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint CREDIT_FLOOR = -64'sh0000_8000_0000_0000;

   logic [31:0]    ring_mem [MEM_DEPTH];
   int unsigned    word_pos;
   logic [31:0]    frame_seq;
   longint         credit;
   logic [7:0]     distance;
   logic [15:0]    budget;
   dgram_word_type datagram_due [$];
   dgram_word_type head;
   int             fault_count = 0;

   function automatic longint credit_sat(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > CREDIT_CEIL) return CREDIT_CEIL;
      if (s < CREDIT_FLOOR) return CREDIT_FLOOR;
      return s;
   endfunction

   // one input word in, the datagram words it releases queued
   function automatic void frame_step(input logic [31:0] w);
      int unsigned slot;
      int unsigned src;
      logic [31:0] back;
      logic        do_append;
      if (word_pos == 0) begin
         frame_seq = w;
         word_pos  = 1;
         datagram_due.push_back('{w, 1'b0, 1'b0});
         return;
      end
      slot = frame_seq % RING_SLOTS;
      ring_mem[slot * PAYLOAD_WORDS + word_pos - 1] = w;
      if (word_pos < PAYLOAD_WORDS) begin
         word_pos++;
         datagram_due.push_back('{w, 1'b0, 1'b0});
         return;
      end
      word_pos  = 0;
      credit    = credit_sat(credit, longint'(budget));
      do_append = (frame_seq >= 32'(distance)) && (credit >= COST_DOUBLE);
      if (!do_append) begin
         credit = credit_sat(credit, -COST_PLAIN);
         datagram_due.push_back('{w, 1'b1, 1'b0});
         return;
      end
      credit = credit_sat(credit, -COST_DOUBLE);
      datagram_due.push_back('{w, 1'b0, 1'b0});
      back = frame_seq - 32'(distance);
      src  = back % RING_SLOTS;
      for (int i = 0; i < PAYLOAD_WORDS; i++) begin
         datagram_due.push_back('{ring_mem[src * PAYLOAD_WORDS + i],
                                  (i == PAYLOAD_WORDS - 1), 1'b1});
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (ring_mem[k]) ring_mem[k] = '0;
         word_pos  = 0;
         frame_seq = '0;
         credit    = 0;
         distance  = RESET_DISTANCE;
         budget    = RESET_BUDGET;
         datagram_due.delete();
      end else begin
         // results first, so a word cannot match a prediction made this same edge
         if (rsp_valid && rsp_ready) begin
            if (datagram_due.size() == 0) begin
               $error("unexpected item: out_word %08h out_last %0b out_copy %0b",
                      rsp_word, rsp_last, rsp_copy);
               fault_count++;
            end else begin
               head = datagram_due.pop_front();
               if (head.word !== rsp_word) begin
                  $error("out_word: expected %08h, got %08h", head.word, rsp_word);
                  fault_count++;
               end
               if (head.last !== rsp_last) begin
                  $error("out_last: expected %0b, got %0b", head.last, rsp_last);
                  fault_count++;
               end
               if (head.copy !== rsp_copy) begin
                  $error("out_copy: expected %0b, got %0b", head.copy, rsp_copy);
                  fault_count++;
               end
            end
         end
         if (req_valid && req_ready) frame_step(req_word);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[2]))
               REG_DISTANCE: distance = csr_pwdata[7:0];
               REG_BUDGET:   budget   = csr_pwdata[15:0];
               default: ;
            endcase
         end
      end
      mismatches  <= fault_count;
      outstanding <= datagram_due.size();
   end

endmodule

FILE: dv/tb.sv
// Testbench top for the redundant frame inserter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
   import rfi_pkg::*;

   localparam int FRAME_WORDS    = PAYLOAD_WORDS + 1;
   localparam int TOTAL_ITEMS    = 370;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int END_SETTLE     = 50;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int due_count;

   // stimulus bookkeeping shared by the sender and the receiver
   int items_sent   = 0;
   int tx_gap_pct   = 0;
   int rx_stall_pct = 0;
   bit calm         = 1'b0;
   int idle_cycles  = 0;

   rfi_req_if req_if ();
   rfi_rsp_if rsp_if ();

   redundant_frame_inserter u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .pready   (csr_pready)
   );

   rfi_scoreboard u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_word    (req_if.in_word),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_word    (rsp_if.out_word),
      .rsp_last    (rsp_if.out_last),
      .rsp_copy    (rsp_if.out_copy),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatch_count),
      .outstanding (due_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: ready drops in random bursts; the odds are set per frame,
   // and zero odds give stretches with no back-pressure at all.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (!calm && rx_stall_pct != 0 &&
                      $urandom_range(1, 100) <= rx_stall_pct) begin
            rsp_if.ready = 1'b0;
            stall_left   = $urandom_range(1, 3) - 1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves an item. The longest
   // honest gap is a register write or the settle time at the end, well below this.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One input item; called at a falling edge, returns at the falling edge after
   // the item was taken. An optional gap of random length goes in front of it.
   task automatic send_item(input logic [31:0] w);
      if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid   = 1'b1;
      req_if.in_word = w;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // A whole frame: sequence word, then the payload. The alternating pattern puts
   // all-zero and all-one words into the ring for a later append to read back.
   // Once the closing stretch is flagged it stays calm to the end.
   task automatic send_frame(input logic [31:0] seq, input bit alternating);
      logic [31:0] w;
      calm = calm || (tx_gap_pct == -1);
      if (calm) begin
         tx_gap_pct   = 0;
         rx_stall_pct = 0;
      end else begin
         tx_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 2);
         rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 15 * $urandom_range(1, 2);
      end
      for (int k = 0; k < FRAME_WORDS; k++) begin
         if (k == 0) begin
            w = seq;
         end else if (alternating) begin
            w = k[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
         end else begin
            w = $urandom();
         end
         send_item(w);
      end
      req_if.valid = 1'b0;
   endtask

   // Hold the sender until every predicted word has left the block.
   task automatic drain();
      do @(posedge clock); while (due_count != 0);
      @(negedge clock);
   endtask

   // APB write: setup, then access; the register takes the value once pready is
   // seen with the access phase. Bits above the register are noise the block drops.
   task automatic csr_write(input csr_index_type idx, input logic [15:0] value);
      logic [31:0] noise;
      noise       = $urandom();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = (idx == REG_DISTANCE) ? {noise[31:8], value[7:0]}
                                          : {noise[31:16], value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Next sequence number: consecutive half the time so the ring slots hold real data,
   // sometimes small (0 to 15, mostly below the distance, so no append), near the 2^32 wrap, or wild.
   function automatic logic [31:0] pick_sequence(input logic [31:0] prev);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return prev + 32'd1;
      if (roll < 70) return 32'($urandom_range(0, 15));
      if (roll < 85) return 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
      return $urandom();
   endfunction

   initial begin
      logic [31:0] seq;
      logic [7:0]  dist_val;
      logic [15:0] budget_val;
      int          phase;
      int          item_goal;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.in_word = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset settings (distance 2, 3168 tenths per frame). Frame 0
      // ends plainly since the credit is short of the doubled cost; frame 2 then
      // has the credit and appends frame 0's alternating payload.
      send_frame(32'd0, 1'b1);
      send_frame(32'd2, 1'b0);
      seq = 32'd2;

      // Random part. Each phase waits for the block to go idle, rewrites both
      // registers and sends one or two frames. The first phases take the extremes:
      // distance one with the richest budget, longest distance with none,
      // distance zero (own slot appended), then the longest with a full budget.
      item_goal = TOTAL_ITEMS;
      phase     = 0;
      while (items_sent + FRAME_WORDS <= item_goal) begin
         drain();
         case (phase)
            0: begin dist_val = 8'd1;   budget_val = 16'hFFFF; end
            1: begin dist_val = 8'd255; budget_val = 16'h0000; end
            2: begin dist_val = 8'd0;   budget_val = 16'hFFFF; end
            3: begin dist_val = 8'd255; budget_val = 16'hFFFF; end
            default: begin
               dist_val = 8'($urandom_range(0, 255));
               case ($urandom_range(0, 3))
                  0:       budget_val = 16'h0000;
                  1:       budget_val = 16'hFFFF;
                  default: budget_val = 16'($urandom());
               endcase
            end
         endcase
         csr_write(REG_DISTANCE, {8'h00, dist_val});
         csr_write(REG_BUDGET, budget_val);
         // the closing frames, the last one or two, run without any idling on either side
         if (items_sent + 3 * FRAME_WORDS > item_goal) tx_gap_pct = -1;
         repeat ($urandom_range(1, 2)) begin
            if (items_sent + FRAME_WORDS <= item_goal) begin
               seq = pick_sequence(seq);
               send_frame(seq, 1'b0);
            end
         end
         phase++;
      end

      drain();
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && due_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
